// ===== design/rdq_pkg.sv =====
// Shared types and codes for the ring buffer deque unit.
package rdq_pkg;

    localparam int WORD_W   = 64;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int M_DATA_W = 72;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One-cycle move command broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_cell_ctrl;

endpackage

// ===== design/rdq_cell.sv =====
// One storage cell of the deque chain: a word and its occupied flag.
module rdq_cell
    import rdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [WORD_W-1:0] i_push_word,
    input  logic              i_left_occ,
    input  logic [WORD_W-1:0] i_left_data,
    input  logic              i_right_occ,
    input  logic [WORD_W-1:0] i_right_data,
    output logic              o_occ,
    output logic [WORD_W-1:0] o_data,
    output logic [WORD_W-1:0] o_tail_data
);

    logic              r_occ;
    logic              n_occ;
    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic              tail;

    assign tail = r_occ && !i_right_occ;

    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        if (i_ctrl.push_front) begin
            // shift toward the back
            n_occ  = i_left_occ;
            n_data = i_left_data;
        end else if (i_ctrl.push_back) begin
            // first free cell takes the word
            if (!r_occ && i_left_occ) begin
                n_occ  = 1'b1;
                n_data = i_push_word;
            end
        end else if (i_ctrl.pop_front) begin
            // shift toward the front
            n_occ  = i_right_occ;
            n_data = i_right_data;
        end else if (i_ctrl.pop_back) begin
            if (tail) begin
                n_occ = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_occ       = r_occ;
    assign o_data      = r_data;
    assign o_tail_data = tail ? r_data : '0;

endmodule

// ===== design/ring_buffer_deque_unit.sv =====
// Top level of the ring buffer deque unit: cell chain, count and result register.
//
// Usage: a double-ended queue of DEPTH 64-bit words.
// Slave channel: i_s_tuser carries the operation (push front, push back,
// pop front, pop back), i_s_tdata the word to push (ignored on pops).
// Master channel: one result word per operation with the popped word
// (zero on pushes and rejected pops), a status (done, push rejected
// because full, pop rejected because empty), the count after the
// operation and an empty flag.
// Storage is a row of cells; words sit packed from cell 0 (the front).
// A push or pop at the front shifts every cell one place together; at
// the back only the cell at the boundary changes.
// Latency: the result is registered and valid the cycle after accept.
// Throughput: one operation per cycle while results are taken, set by the single cell update.
// A new word is taken while a result waits, as long as that result is
// taken in the same cycle; if the receiver stalls, the result holds and
// o_s_tready drops until it is taken.
// Reset clears the count, the occupied flags and the output valid; no
// clearing pass is needed.
module ring_buffer_deque_unit
    import rdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [WORD_W-1:0]   i_s_tdata,  // [63:0] push_word
    input  logic [KIND_W-1:0]   i_s_tuser,  // [1:0] kind
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [63:0] popped_word, [65:64] status, [70:66] fill_count, [71] is_empty
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_valid;
    logic              n_valid;
    logic [WORD_W-1:0] r_popped;
    logic [WORD_W-1:0] n_popped;
    t_status           r_status;
    t_status           n_status;

    logic              accept;
    logic              full;
    logic              empty;
    t_kind             kind;
    t_cell_ctrl        ctrl;
    logic [WORD_W-1:0] tail_word;

    logic              cell_occ  [DEPTH];
    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [WORD_W-1:0] cell_tail [DEPTH];

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign kind       = t_kind'(i_s_tuser);

    // Decode the operation; drop moves that would overflow or underflow.
    always_comb begin
        ctrl     = '0;
        n_count  = r_count;
        n_status = ST_DONE;
        n_popped = '0;
        case (kind)
            KIND_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.push_front = accept;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            KIND_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.push_back = accept;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.pop_front = accept;
                    n_count        = r_count - CNT_W'(1);
                    n_popped       = cell_data[0];
                end
            end
            KIND_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.pop_back = accept;
                    n_count       = r_count - CNT_W'(1);
                    n_popped      = tail_word;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Only the last occupied cell drives its word; merge them.
    always_comb begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_word = tail_word | cell_tail[i];
        end
    end

    // Cell chain: cell 0 is the front; cell 0 sees the pushed word on its
    // left, the last cell sees an empty neighbor on its right.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              left_occ;
        logic [WORD_W-1:0] left_data;
        logic              right_occ;
        logic [WORD_W-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_occ  = 1'b1;
            assign left_data = i_s_tdata;
        end else begin : g_mid_l
            assign left_occ  = cell_occ[g-1];
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_occ  = 1'b0;
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_occ  = cell_occ[g+1];
            assign right_data = cell_data[g+1];
        end

        rdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_push_word  (i_s_tdata),
            .i_left_occ   (left_occ),
            .i_left_data  (left_data),
            .i_right_occ  (right_occ),
            .i_right_data (right_data),
            .o_occ        (cell_occ[g]),
            .o_data       (cell_data[g]),
            .o_tail_data  (cell_tail[g])
        );
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload; hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped <= n_popped;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {(r_count == '0), FILL_W'(r_count), r_status, r_popped};

endmodule
